// ----- sv/pwin_pkg.sv -----
// Package with shared types and constants of the PPG window block.
`default_nettype none
package pwin_pkg;
  localparam int SAMPLE_W = 18;
  localparam int ACC_W    = 48;
  localparam logic [1:0] REG_FINGER_THR = 2'd0;
  localparam logic [1:0] REG_ALERT_LOW  = 2'd1;
  localparam logic [1:0] REG_ALERT_HIGH = 2'd2;
  localparam logic [7:0] HR_MIN   = 8'd20;
  localparam logic [7:0] HR_MAX   = 8'd250;
  localparam logic [6:0] SPO2_MIN = 7'd70;
  localparam logic [6:0] SPO2_MAX = 7'd100;
  localparam logic [6:0] SPO2_WEAK = 7'd98;

  // Per-lane extremes (max and min) handed to the scan sequencer.
  typedef struct packed {
    logic [SAMPLE_W-1:0] mx;
    logic [SAMPLE_W-1:0] mn;
  } lane_ext_t;
endpackage
`default_nettype wire

// ----- sv/ppg_heart_rate_spo2_window.sv -----
// Top level of the PPG heart rate and SpO2 window block.
// Usage:
//   Input beats (in_red_level, in_ir_level, in_batch_end) are taken when
//   in_valid is high and in_stall is low. Each beat is written into a
//   circular window of WINDOW_SIZE pairs, which must be a power of two.
//   A beat without batch end only writes the window. A batch-end beat starts
//   a scan: two lanes (red, IR) walk the window twice, summing on the first
//   pass and squaring and counting crossings on the second. Then the shared
//   square-root unit runs twice (IR, then red) and the divider once, unless
//   the SpO2 value is settled without the divider; the result is registered.
//   One result beat appears on out_* with out_valid; it holds while
//   out_stall is high. A new input is accepted once the result is in the
//   output register. Reset clears the window with a sweep over all
//   WINDOW_SIZE entries, during which no input is accepted; configuration
//   registers return to 50000, 40 and 150. cfg writes take effect at once.
`default_nettype none
module ppg_heart_rate_spo2_window #(
  parameter int WINDOW_SIZE = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [17:0] in_red_level,
  input  wire logic [17:0] in_ir_level,
  input  wire logic        in_batch_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_heart_rate,
  output logic [6:0]       out_oxygen_saturation,
  output logic             out_finger_present,
  output logic             out_vital_alert,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [17:0] cfg_data
);
  import pwin_pkg::*;
  localparam int AW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] LAST = CW'(WINDOW_SIZE - 1);
  localparam int LOGN = $clog2(WINDOW_SIZE);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_PASS1, S_DC, S_PASS2, S_SQ_IR, S_SQ_RED,
    S_DIV, S_FIN
  } state_t;

  state_t state_r;
  logic [SAMPLE_W-1:0] red_mem [WINDOW_SIZE];
  logic [SAMPLE_W-1:0] ir_mem  [WINDOW_SIZE];
  logic [AW-1:0] wpos_r, rd_addr;
  logic [CW-1:0] cnt_r;
  logic [SAMPLE_W-1:0] red_q_r, ir_q_r;
  logic [SAMPLE_W-1:0] ir0_r;
  logic [SAMPLE_W-1:0] thr_cfg_r;
  logic [7:0] low_cfg_r, high_cfg_r;
  logic [1:0] pass_r;
  logic q_vld_r;
  logic clr_lanes, en_sum, en_sq;
  logic [ACC_W-1:0] red_sum, ir_sum, red_sq, ir_sq;
  lane_ext_t red_ext, ir_ext;
  logic [SAMPLE_W-1:0] red_dc_r, ir_dc_r, mid_r;
  logic above_r;
  logic [AW:0] peaks_r;
  logic [31:0] sq_root;
  logic sq_done, sq_start;
  logic [63:0] sq_arg;
  logic [31:0] ir_ac_r, red_ac_r;
  logic div_start, div_done;
  logic [63:0] div_quot, div_num, div_den;
  logic [7:0] hr_val;
  logic [6:0] sp_r;
  logic out_full_r;

  // Division by the window size, a power of two.
  function automatic logic [ACC_W-1:0] div_n(input logic [ACC_W-1:0] v);
    return v >> LOGN;
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_full_r;

  // Window memories with registered reads.
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      red_mem[cnt_r[AW-1:0]] <= '0;
      ir_mem[cnt_r[AW-1:0]]  <= '0;
    end else if (in_valid && !in_stall) begin
      red_mem[wpos_r] <= in_red_level;
      ir_mem[wpos_r]  <= in_ir_level;
    end
    red_q_r <= red_mem[rd_addr];
    ir_q_r  <= ir_mem[rd_addr];
  end
  assign rd_addr = cnt_r[AW-1:0];

  pwin_lane u_red (.clk, .clr(clr_lanes), .en_sum, .en_sq, .sample(red_q_r),
    .dc(red_dc_r), .sum_r(red_sum), .sq_r(red_sq), .ext_r(red_ext));
  pwin_lane u_ir (.clk, .clr(clr_lanes), .en_sum, .en_sq, .sample(ir_q_r),
    .dc(ir_dc_r), .sum_r(ir_sum), .sq_r(ir_sq), .ext_r(ir_ext));

  assign clr_lanes = (state_r == S_RD);
  assign en_sum = q_vld_r && (pass_r == 2'd1);
  assign en_sq  = q_vld_r && (pass_r == 2'd2);

  // Shared square root and divider. The mean square in Q16 is the sum of
  // squares scaled by 2^16 and divided by the window size.
  assign sq_arg = (state_r == S_SQ_IR) ? (64'(ir_sq) << (16 - LOGN))
                                       : (64'(red_sq) << (16 - LOGN));
  pwin_isqrt u_sqrt (.clk, .rst_n, .start(sq_start), .radicand(sq_arg),
    .done_r(sq_done), .root_r(sq_root));
  assign div_num = 64'({red_ac_r, 16'd0}) * 64'(ir_dc_r) ;
  assign div_den = 64'(red_dc_r) * 64'(ir_ac_r);
  pwin_div u_div (.clk, .rst_n, .start(div_start), .dividend(div_num),
    .divisor(div_den), .done_r(div_done), .quot_r(div_quot));

  // Heart rate from peak count.
  always_comb begin
    logic [31:0] b;
    b = 32'(peaks_r) * 32'd6000 / WINDOW_SIZE;
    if (b < 32'(HR_MIN)) hr_val = HR_MIN;
    else if (b > 32'(HR_MAX)) hr_val = HR_MAX;
    else hr_val = b[7:0];
  end

  // Scan sequencer, configuration and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      cnt_r      <= '0;
      wpos_r     <= '0;
      out_full_r <= 1'b0;
      q_vld_r    <= 1'b0;
      pass_r     <= '0;
      sq_start   <= 1'b0;
      div_start  <= 1'b0;
      thr_cfg_r  <= 18'd50000;
      low_cfg_r  <= 8'd40;
      high_cfg_r <= 8'd150;
    end else begin
      sq_start  <= 1'b0;
      div_start <= 1'b0;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_FINGER_THR: thr_cfg_r  <= cfg_data;
          REG_ALERT_LOW:  low_cfg_r  <= cfg_data[7:0];
          REG_ALERT_HIGH: high_cfg_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_full_r && !out_stall) out_full_r <= 1'b0;
      q_vld_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == LAST) begin
            cnt_r <= '0;
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            wpos_r <= (wpos_r == LAST[AW-1:0]) ? '0 : wpos_r + AW'(1);
            if (in_batch_end) begin
              state_r <= S_RD;
              cnt_r   <= '0;
            end
          end
        end
        S_RD: begin
          pass_r  <= 2'd1;
          state_r <= S_PASS1;
          q_vld_r <= 1'b1;
          cnt_r   <= cnt_r + CW'(1);
          above_r <= 1'b0;
          peaks_r <= '0;
        end
        S_PASS1: begin
          // Pass 1 accumulates; pass 2 squares and counts crossings.
          if (pass_r == 2'd1 && cnt_r == CW'(1)) ir0_r <= ir_q_r;
          if (pass_r == 2'd2 && q_vld_r) begin
            if (!above_r && ir_q_r > mid_r) begin
              peaks_r <= peaks_r + CW'(1);
              above_r <= 1'b1;
            end else if (above_r && ir_q_r <= mid_r) above_r <= 1'b0;
          end
          if (cnt_r == CW'(WINDOW_SIZE)) begin
            cnt_r <= '0;
            state_r <= (pass_r == 2'd1) ? S_DC : S_PASS2;
          end else begin
            cnt_r <= cnt_r + CW'(1);
            q_vld_r <= 1'b1;
          end
        end
        S_DC: begin
          if (!q_vld_r && pass_r == 2'd1) begin
            red_dc_r <= SAMPLE_W'(div_n(red_sum));
            ir_dc_r  <= SAMPLE_W'(div_n(ir_sum));
            mid_r    <= SAMPLE_W'((19'(ir_ext.mx) + 19'(ir_ext.mn)) >> 1);
            pass_r   <= 2'd2;
            state_r  <= S_PASS1;
            cnt_r    <= cnt_r + CW'(1);
            q_vld_r  <= 1'b1;
          end else if (pass_r == 2'd3) begin
            sq_start <= 1'b1;
            state_r  <= S_SQ_IR;
          end
        end
        S_PASS2: begin
          pass_r  <= 2'd3;
          state_r <= S_DC;
        end
        S_SQ_IR: begin
          if (sq_done) begin
            ir_ac_r  <= sq_root;
            sq_start <= 1'b1;
            state_r  <= S_SQ_RED;
          end
        end
        S_SQ_RED: begin
          if (sq_done) begin
            red_ac_r <= sq_root;
            if (ir_dc_r == '0 || ir_ac_r < 32'd256) begin
              sp_r <= SPO2_WEAK;
              state_r <= S_FIN;
            end else if (red_dc_r == '0) begin
              sp_r <= SPO2_MIN;
              state_r <= S_FIN;
            end else begin
              div_start <= 1'b1;
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_start) ;
          else if (div_done) begin
            if (div_quot >= 64'd131072) sp_r <= SPO2_MIN;
            else begin
              logic [23:0] t;
              t = 24'((24'd104 << 16) - 24'(div_quot) * 24'd17) >> 16;
              sp_r <= (t > 24'(SPO2_MAX)) ? SPO2_MAX :
                      (t < 24'(SPO2_MIN)) ? SPO2_MIN : t[6:0];
            end
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_full_r || !out_stall) begin
            out_full_r <= 1'b1;
            out_heart_rate <= hr_val;
            out_oxygen_saturation <= sp_r;
            out_finger_present <= ir0_r > thr_cfg_r;
            out_vital_alert <= (ir0_r > thr_cfg_r) &&
                               (hr_val < low_cfg_r || hr_val > high_cfg_r);
            pass_r  <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result lost");
  a_spo2_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_oxygen_saturation >= SPO2_MIN &&
                   out_oxygen_saturation <= SPO2_MAX)) else $error("spo2 range");
`endif
endmodule
`default_nettype wire

// ----- sv/pwin_lane.sv -----
// One channel lane: streams window entries and accumulates sum, extremes, squares.
`default_nettype none
module pwin_lane (
  input  wire logic                           clk,
  input  wire logic                           clr,
  input  wire logic                           en_sum,
  input  wire logic                           en_sq,
  input  wire logic [pwin_pkg::SAMPLE_W-1:0]  sample,
  input  wire logic [pwin_pkg::SAMPLE_W-1:0]  dc,
  output logic      [pwin_pkg::ACC_W-1:0]     sum_r,
  output logic      [pwin_pkg::ACC_W-1:0]     sq_r,
  output pwin_pkg::lane_ext_t                 ext_r
);
  import pwin_pkg::*;
  logic [SAMPLE_W-1:0] dev;
  logic [2*SAMPLE_W-1:0] dev_sq;

  // Absolute deviation from the mean and its square.
  always_comb begin
    dev    = (sample >= dc) ? sample - dc : dc - sample;
    dev_sq = dev * dev;
  end

  // Accumulators for both passes.
  always_ff @(posedge clk) begin
    if (clr) begin
      sum_r  <= '0;
      sq_r   <= '0;
      ext_r.mx <= '0;
      ext_r.mn <= '1;
    end else begin
      if (en_sum) begin
        sum_r <= sum_r + ACC_W'(sample);
        if (sample > ext_r.mx) ext_r.mx <= sample;
        if (sample < ext_r.mn) ext_r.mn <= sample;
      end
      if (en_sq) sq_r <= sq_r + ACC_W'(dev_sq);
    end
  end
endmodule
`default_nettype wire

// ----- sv/pwin_isqrt.sv -----
// Iterative integer square root, two radicand bits per cycle.
`default_nettype none
module pwin_isqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic             done_r,
  output logic [31:0]      root_r
);
  logic [63:0] rem_r;
  logic [63:0] val_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [65:0] trial;

  always_comb trial = {rem_r, val_r[63:62]} - {32'd0, root_r, 2'b01};

  // Restoring digit recurrence.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rem_r  <= '0;
        root_r <= '0;
        val_r  <= radicand;
        cnt_r  <= '0;
      end else if (busy_r) begin
        val_r <= {val_r[61:0], 2'b00};
        if (!trial[65]) begin
          rem_r  <= trial[63:0];
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          rem_r  <= {rem_r[61:0], val_r[63:62]};
          root_r <= {root_r[30:0], 1'b0};
        end
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- sv/pwin_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module pwin_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             done_r,
  output logic [63:0]      quot_r
);
  logic [63:0] rem_r;
  logic [63:0] dsr_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic [64:0] trial;

  always_comb trial = {rem_r, quot_r[63]} - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rem_r  <= '0;
        quot_r <= dividend;
        dsr_r  <= divisor;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (!trial[64]) begin
          rem_r  <= trial[63:0];
          quot_r <= {quot_r[62:0], 1'b1};
        end else begin
          rem_r  <= {rem_r[62:0], quot_r[63]};
          quot_r <= {quot_r[62:0], 1'b0};
        end
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- bench/tb_ppg_heart_rate_spo2_window.sv -----
// Self-checking testbench for the PPG heart rate and SpO2 window block.
`timescale 1ns / 100ps
`default_nettype none
module tb_ppg_heart_rate_spo2_window;
  import pwin_pkg::*;

  localparam int N_WIN = 32;
  localparam int SETTLE_CYCLES = 400;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic [17:0] SAMPLE_MAX = 18'h3FFFF;

  // Receiver stall styles.
  localparam logic [1:0] RX_FREE = 2'd0;
  localparam logic [1:0] RX_LIGHT = 2'd1;
  localparam logic [1:0] RX_HEAVY = 2'd2;

  typedef struct packed {
    logic [7:0] heart_rate;
    logic [6:0] spo2;
    logic       finger;
    logic       alert;
  } vitals_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [17:0] in_red_level = '0;
  logic [17:0] in_ir_level = '0;
  logic        in_batch_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_heart_rate;
  logic [6:0]  out_oxygen_saturation;
  logic        out_finger_present;
  logic        out_vital_alert;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [17:0] cfg_data = '0;

  // Shadow of the block's window and registers.
  logic [17:0] red_win [N_WIN];
  logic [17:0] ir_win [N_WIN];
  logic [4:0]  wr_pos;
  logic [17:0] finger_thr;
  logic [7:0]  alert_low;
  logic [7:0]  alert_high;

  vitals_t pending_vitals[$];
  int      errors = 0;
  int      burst_left = 0;
  logic [1:0] rx_style = RX_FREE;
  int      rx_left = 0;

  ppg_heart_rate_spo2_window #(.WINDOW_SIZE(N_WIN)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_red_level(in_red_level), .in_ir_level(in_ir_level),
    .in_batch_end(in_batch_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_heart_rate(out_heart_rate), .out_oxygen_saturation(out_oxygen_saturation),
    .out_finger_present(out_finger_present), .out_vital_alert(out_vital_alert),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Bitwise integer square root.
  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Heart rate from IR midpoint crossings over the window.
  function automatic logic [7:0] window_bpm();
    logic [18:0] mx, mn, mid;
    logic [63:0] bpm;
    int peaks;
    bit above;
    mx = 0;
    mn = SAMPLE_MAX;
    peaks = 0;
    above = 0;
    for (int i = 0; i < N_WIN; i++) begin
      if (ir_win[i] > mx) mx = ir_win[i];
      if (ir_win[i] < mn) mn = ir_win[i];
    end
    mid = (mx + mn) >> 1;
    for (int i = 0; i < N_WIN; i++) begin
      if (!above && ir_win[i] > mid) begin
        peaks++;
        above = 1;
      end else if (above && ir_win[i] <= mid) begin
        above = 0;
      end
    end
    bpm = (64'(peaks) * 6000) / N_WIN;
    if (bpm < HR_MIN) bpm = HR_MIN;
    if (bpm > HR_MAX) bpm = HR_MAX;
    return bpm[7:0];
  endfunction

  // SpO2 from the ratio of RMS to mean of both channels.
  function automatic logic [6:0] window_spo2();
    logic [63:0] ir_dc, red_dc, ir_sq, red_sq, di, dr, ir_ac, red_ac, ratio, pct;
    ir_dc = 0; red_dc = 0; ir_sq = 0; red_sq = 0;
    for (int i = 0; i < N_WIN; i++) begin
      ir_dc += ir_win[i];
      red_dc += red_win[i];
    end
    ir_dc = ir_dc / N_WIN;
    red_dc = red_dc / N_WIN;
    for (int i = 0; i < N_WIN; i++) begin
      di = (ir_win[i] >= ir_dc) ? ir_win[i] - ir_dc : ir_dc - ir_win[i];
      dr = (red_win[i] >= red_dc) ? red_win[i] - red_dc : red_dc - red_win[i];
      ir_sq += di * di;
      red_sq += dr * dr;
    end
    ir_ac = int_sqrt((ir_sq << 16) / N_WIN);
    red_ac = int_sqrt((red_sq << 16) / N_WIN);
    if (ir_dc == 0 || ir_ac < 256) return SPO2_WEAK;
    if (red_dc == 0) return SPO2_MIN;
    ratio = ((red_ac * ir_dc) << 16) / (red_dc * ir_ac);
    if (ratio >= 131072) return SPO2_MIN;
    pct = ((64'd104 << 16) - 17 * ratio) >> 16;
    if (pct > SPO2_MAX) pct = SPO2_MAX;
    if (pct < SPO2_MIN) pct = SPO2_MIN;
    return pct[6:0];
  endfunction

  // Store one accepted beat and queue the vitals it produces.
  task automatic store_sample(logic [17:0] red, logic [17:0] ir, logic last);
    vitals_t v;
    red_win[wr_pos] = red;
    ir_win[wr_pos] = ir;
    wr_pos = wr_pos + 5'd1;
    if (last) begin
      v.heart_rate = window_bpm();
      v.spo2 = window_spo2();
      v.finger = ir_win[0] > finger_thr;
      v.alert = v.finger && (v.heart_rate < alert_low || v.heart_rate > alert_high);
      pending_vitals.push_back(v);
    end
  endtask

  // Send one beat, with bursts and random gaps on the input side.
  task automatic send_sample(logic [17:0] red, logic [17:0] ir, logic last);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_red_level <= red;
    in_ir_level <= ir;
    in_batch_end <= last;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    store_sample(red, ir, last);
    burst_left--;
  endtask

  // One register write; the strobe is high for a single cycle and drops before the next write.
  task automatic write_reg(logic [1:0] idx, logic [17:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_FINGER_THR: finger_thr = val;
      REG_ALERT_LOW:  alert_low = val[7:0];
      REG_ALERT_HIGH: alert_high = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Let the block drain completely before touching the registers.
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_vitals.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed();
    // Empty window: no IR level at all.
    send_sample(18'd0, 18'd0, 1'b1);
    // Red channel dark while IR pulses.
    for (int i = 0; i < 6; i++)
      send_sample(18'd0, (i % 2) ? 18'd200000 : 18'd10000, i == 5);
    // Strong red pulse against a weak IR swing gives a large ratio.
    for (int i = 0; i < 6; i++)
      send_sample((i % 2) ? 18'd90000 : 18'd100, (i % 2) ? 18'd150000 : 18'd149000, i == 5);
    // Full-scale and single-bit samples.
    send_sample(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
    send_sample(18'd1, 18'd1, 1'b1);
    // Many crossings for a clamped high rate.
    for (int i = 0; i < 8; i++)
      send_sample(18'd120000 + 18'(i * 100), (i % 2) ? 18'd180000 : 18'd60000, i == 7);
    send_sample(18'h2AAAA, 18'h15555, 1'b1);
  endtask

  // Mostly pulse-shaped batches with random content, some raw noise.
  task automatic test_random(int n_items);
    int sent, len, period, ir_amp, red_amp;
    logic [17:0] ir_base, red_base, r, ir;
    bit noise;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : N_WIN;
      noise = ($urandom_range(0, 6) == 0);
      period = $urandom_range(2, 40);
      ir_amp = $urandom_range(0, 60000);
      red_amp = $urandom_range(0, 60000);
      ir_base = 18'($urandom_range(0, 200000));
      red_base = 18'($urandom_range(0, 200000));
      for (int i = 0; i < len; i++) begin
        if (noise) begin
          r = 18'($urandom_range(0, SAMPLE_MAX));
          ir = 18'($urandom_range(0, SAMPLE_MAX));
        end else begin
          ir = ir_base + (((i % period) < period / 2) ? 18'(ir_amp) : 18'd0);
          r = red_base + (((i % period) < period / 2) ? 18'(red_amp) : 18'd0);
        end
        send_sample(r, ir, (i == len - 1) || ($urandom_range(0, 40) == 0));
        sent++;
      end
    end
  endtask

  // Receiver stall pattern: calm, light and heavy stretches.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_style <= 2'($urandom_range(0, 2));
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_style)
      RX_FREE:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall <= ($urandom_range(0, 4) != 0);
      default:  out_stall <= 1'b0;
    endcase
  end

  // Compare each accepted result beat with the oldest prediction.
  always @(negedge clk) begin
    vitals_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_vitals.size() == 0) begin
        $display("%0t: unexpected result beat hr=%0d spo2=%0d", $time,
                 out_heart_rate, out_oxygen_saturation);
        errors++;
      end else begin
        want = pending_vitals.pop_front();
        if (out_heart_rate !== want.heart_rate) begin
          $display("%0t: heart_rate expected %0d got %0d", $time, want.heart_rate,
                   out_heart_rate);
          errors++;
        end
        if (out_oxygen_saturation !== want.spo2) begin
          $display("%0t: oxygen_saturation expected %0d got %0d", $time, want.spo2,
                   out_oxygen_saturation);
          errors++;
        end
        if (out_finger_present !== want.finger) begin
          $display("%0t: finger_present expected %0d got %0d", $time, want.finger,
                   out_finger_present);
          errors++;
        end
        if (out_vital_alert !== want.alert) begin
          $display("%0t: vital_alert expected %0d got %0d", $time, want.alert,
                   out_vital_alert);
          errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    for (int i = 0; i < N_WIN; i++) begin
      red_win[i] = '0;
      ir_win[i] = '0;
    end
    wr_pos = '0;
    finger_thr = 18'd50000;
    alert_low = 8'd40;
    alert_high = 8'd150;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(200);
    wait_idle();

    // Everything present, alert on any rate.
    write_reg(REG_FINGER_THR, 18'd0);
    write_reg(REG_ALERT_LOW, 18'd255);
    write_reg(REG_ALERT_HIGH, 18'd0);
    write_reg(REG_UNUSED, SAMPLE_MAX);
    test_random(200);
    wait_idle();

    // No finger ever, widest limits.
    write_reg(REG_FINGER_THR, SAMPLE_MAX);
    write_reg(REG_ALERT_LOW, 18'd0);
    write_reg(REG_ALERT_HIGH, 18'd255);
    test_random(150);
    wait_idle();

    // Mid threshold with limits around the reachable rates.
    write_reg(REG_FINGER_THR, 18'd120000);
    write_reg(REG_ALERT_LOW, 18'd21);
    write_reg(REG_ALERT_HIGH, 18'd187);
    test_random(250);
    wait_idle();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
